### hw/rtl/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared types and constants of the advertising data parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdp_pkg;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [2:0] REG_QUERY_UUID    = 3'd0;
  localparam logic [2:0] REG_QUERY_INDEX   = 3'd1;
  localparam logic [2:0] REG_COMPLETE_NAME = 3'd2;
  localparam logic [2:0] REG_SHORT_NAME    = 3'd3;
  localparam logic [2:0] REG_PARTIAL_LIST  = 3'd4;
  localparam logic [2:0] REG_FULL_LIST     = 3'd5;

  localparam logic [7:0] RST_COMPLETE_NAME = 8'd9;
  localparam logic [7:0] RST_SHORT_NAME    = 8'd8;
  localparam logic [7:0] RST_PARTIAL_LIST  = 8'd2;
  localparam logic [7:0] RST_FULL_LIST     = 8'd3;

  localparam int NUM_KINDS     = 4;
  localparam int KIND_COMPLETE = 0;
  localparam int KIND_SHORT    = 1;
  localparam int KIND_PARTIAL  = 2;
  localparam int KIND_FULL     = 3;

  typedef struct packed {
    logic [15:0] query_uuid;
    logic [7:0]  query_index;
    logic [7:0]  complete_name_type;
    logic [7:0]  short_name_type;
    logic [7:0]  partial_list_type;
    logic [7:0]  full_list_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] name_type;
    logic [7:0] name_offset;
    logic [7:0] name_length;
    logic       has_uuid;
    logic [6:0] uuid_count;
    logic [6:0] partial_count;
    logic [6:0] full_count;
    logic [7:0] partial_offset;
    logic [7:0] full_offset;
  } summary_t;

endpackage

`default_nettype wire

### hw/rtl/bdp_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdp_cfg_regs
// APB register file holding the query and AD type code registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bdp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bdp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bdp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output bdp_pkg::cfg_t                   cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[bdp_pkg::APB_ADDR_W-1:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.query_uuid         <= 16'd0;
      cfg.query_index        <= 8'd0;
      cfg.complete_name_type <= bdp_pkg::RST_COMPLETE_NAME;
      cfg.short_name_type    <= bdp_pkg::RST_SHORT_NAME;
      cfg.partial_list_type  <= bdp_pkg::RST_PARTIAL_LIST;
      cfg.full_list_type     <= bdp_pkg::RST_FULL_LIST;
    end else if (wr_en) begin
      case (reg_index)
        bdp_pkg::REG_QUERY_UUID:    cfg.query_uuid         <= pwdata[15:0];
        bdp_pkg::REG_QUERY_INDEX:   cfg.query_index        <= pwdata[7:0];
        bdp_pkg::REG_COMPLETE_NAME: cfg.complete_name_type <= pwdata[7:0];
        bdp_pkg::REG_SHORT_NAME:    cfg.short_name_type    <= pwdata[7:0];
        bdp_pkg::REG_PARTIAL_LIST:  cfg.partial_list_type  <= pwdata[7:0];
        bdp_pkg::REG_FULL_LIST:     cfg.full_list_type     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      bdp_pkg::REG_QUERY_UUID:    prdata = {16'd0, cfg.query_uuid};
      bdp_pkg::REG_QUERY_INDEX:   prdata = {24'd0, cfg.query_index};
      bdp_pkg::REG_COMPLETE_NAME: prdata = {24'd0, cfg.complete_name_type};
      bdp_pkg::REG_SHORT_NAME:    prdata = {24'd0, cfg.short_name_type};
      bdp_pkg::REG_PARTIAL_LIST:  prdata = {24'd0, cfg.partial_list_type};
      bdp_pkg::REG_FULL_LIST:     prdata = {24'd0, cfg.full_list_type};
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/bdp_field_walker.sv
// ----------------------------------------------------------------------------
// bdp_field_walker
// Input register, per-byte length-type-value walk and packet summary register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdp_field_walker #(
  parameter int PACKET_BYTES = 255
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bdp_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              last_byte,
  input  logic                              s3_ready,
  output logic                              sum_valid,
  output bdp_pkg::summary_t                 summary,
  output logic                              wr_en,
  output logic [$clog2(PACKET_BYTES)-1:0]   wr_addr,
  output logic [7:0]                        wr_data
);

  localparam int POSW = $clog2(PACKET_BYTES + 1);
  localparam int IDXW = $clog2(PACKET_BYTES);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_BODY
  } phase_t;

  logic                s1_valid;
  logic [7:0]          byte_q;
  logic                last_q;
  logic                freeze;
  logic                step;
  logic                accept;

  logic [POSW-1:0]     pos, pos_next;
  phase_t              phase, phase_next;
  logic                stopped, stopped_next;
  logic [3:0]          found, found_next;
  logic [7:0]          offs [bdp_pkg::NUM_KINDS];
  logic [7:0]          offs_next [bdp_pkg::NUM_KINDS];
  logic [7:0]          lens [bdp_pkg::NUM_KINDS];
  logic [7:0]          lens_next [bdp_pkg::NUM_KINDS];
  logic [7:0]          flen, flen_next;
  logic [7:0]          fstart, fstart_next;
  logic [7:0]          plen, plen_next;
  logic [7:0]          rem, rem_next;
  logic [3:0]          cand, cand_next;
  logic                parity, parity_next;
  logic                field_hit, field_hit_next;
  logic                hit_committed, hit_committed_next;
  logic [7:0]          low_hold, low_hold_next;
  logic                store;
  logic                live;
  logic                commit;
  logic [3:0]          match;
  logic [6:0]          cp, cf;
  bdp_pkg::summary_t   summary_next;

  assign freeze   = sum_valid && !s3_ready;
  assign in_stall = s1_valid && freeze;
  assign accept   = in_valid && !in_stall;
  assign step     = s1_valid && !freeze;
  assign store    = pos < POSW'(PACKET_BYTES);
  assign live     = step && store && !stopped;

  assign wr_en   = step && store;
  assign wr_addr = IDXW'(pos);
  assign wr_data = byte_q;

  assign match[bdp_pkg::KIND_COMPLETE] = byte_q == cfg.complete_name_type;
  assign match[bdp_pkg::KIND_SHORT]    = byte_q == cfg.short_name_type;
  assign match[bdp_pkg::KIND_PARTIAL]  = byte_q == cfg.partial_list_type;
  assign match[bdp_pkg::KIND_FULL]     = byte_q == cfg.full_list_type;

  always_comb begin
    pos_next           = pos;
    phase_next         = phase;
    stopped_next       = stopped;
    found_next         = found;
    flen_next          = flen;
    fstart_next        = fstart;
    plen_next          = plen;
    rem_next           = rem;
    cand_next          = cand;
    parity_next        = parity;
    field_hit_next     = field_hit;
    hit_committed_next = hit_committed;
    low_hold_next      = low_hold;
    commit             = 1'b0;
    for (int k = 0; k < bdp_pkg::NUM_KINDS; k++) begin
      offs_next[k] = offs[k];
      lens_next[k] = lens[k];
    end

    if (step && store) begin
      pos_next = pos + POSW'(1);
    end

    if (live) begin
      case (phase)
        PH_LEN: begin
          if (byte_q == 8'd0) begin
            stopped_next = 1'b1;
          end else begin
            flen_next  = byte_q;
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          cand_next      = match & ~found;
          fstart_next    = 8'(pos) + 8'd1;
          plen_next      = flen - 8'd1;
          rem_next       = flen - 8'd1;
          parity_next    = 1'b0;
          field_hit_next = 1'b0;
          if (flen == 8'd1) begin
            commit     = 1'b1;
            phase_next = PH_LEN;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          if (!parity) begin
            low_hold_next = byte_q;
          end else if (cfg.query_uuid == 16'd0 || {byte_q, low_hold} == cfg.query_uuid) begin
            field_hit_next = 1'b1;
          end
          parity_next = ~parity;
          rem_next    = rem - 8'd1;
          if (rem == 8'd1) begin
            commit     = 1'b1;
            phase_next = PH_LEN;
          end
        end
        default: phase_next = PH_LEN;
      endcase
    end

    if (commit) begin
      found_next = found | cand_next;
      for (int k = 0; k < bdp_pkg::NUM_KINDS; k++) begin
        if (cand_next[k]) begin
          offs_next[k] = fstart_next;
          lens_next[k] = plen_next;
        end
      end
      if ((cand_next[bdp_pkg::KIND_PARTIAL] || cand_next[bdp_pkg::KIND_FULL]) && field_hit_next)
      begin
        hit_committed_next = 1'b1;
      end
    end

    cp = found_next[bdp_pkg::KIND_PARTIAL] ? lens_next[bdp_pkg::KIND_PARTIAL][7:1] : 7'd0;
    cf = found_next[bdp_pkg::KIND_FULL] ? lens_next[bdp_pkg::KIND_FULL][7:1] : 7'd0;

    summary_next = '0;
    if (found_next[bdp_pkg::KIND_COMPLETE]) begin
      summary_next.name_type   = cfg.complete_name_type;
      summary_next.name_offset = offs_next[bdp_pkg::KIND_COMPLETE];
      summary_next.name_length = lens_next[bdp_pkg::KIND_COMPLETE];
    end else if (found_next[bdp_pkg::KIND_SHORT]) begin
      summary_next.name_type   = cfg.short_name_type;
      summary_next.name_offset = offs_next[bdp_pkg::KIND_SHORT];
      summary_next.name_length = lens_next[bdp_pkg::KIND_SHORT];
    end
    summary_next.has_uuid       = hit_committed_next;
    summary_next.uuid_count     = 7'({1'b0, cp} + {1'b0, cf});
    summary_next.partial_count  = cp;
    summary_next.full_count     = cf;
    summary_next.partial_offset = offs_next[bdp_pkg::KIND_PARTIAL];
    summary_next.full_offset    = offs_next[bdp_pkg::KIND_FULL];

    if (step && last_q) begin
      pos_next           = '0;
      phase_next         = PH_LEN;
      stopped_next       = 1'b0;
      found_next         = '0;
      hit_committed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      sum_valid     <= 1'b0;
      pos           <= '0;
      phase         <= PH_LEN;
      stopped       <= 1'b0;
      found         <= '0;
      hit_committed <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (step) begin
        s1_valid <= 1'b0;
      end
      if (step && last_q) begin
        sum_valid <= 1'b1;
      end else if (sum_valid && s3_ready) begin
        sum_valid <= 1'b0;
      end
      pos           <= pos_next;
      phase         <= phase_next;
      stopped       <= stopped_next;
      found         <= found_next;
      hit_committed <= hit_committed_next;
    end
    if (accept) begin
      byte_q <= data_byte;
      last_q <= last_byte;
    end
    if (step && last_q) begin
      summary <= summary_next;
    end
    flen      <= flen_next;
    fstart    <= fstart_next;
    plen      <= plen_next;
    rem       <= rem_next;
    cand      <= cand_next;
    parity    <= parity_next;
    field_hit <= field_hit_next;
    low_hold  <= low_hold_next;
    for (int k = 0; k < bdp_pkg::NUM_KINDS; k++) begin
      offs[k] <= offs_next[k];
      lens[k] <= lens_next[k];
    end
  end

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !s3_ready |=> sum_valid && $stable(summary))
    else $error("summary changed while held");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POSW'(PACKET_BYTES))
    else $error("byte position past packet limit");

  a_packet_restart: assert property (@(posedge clk) disable iff (rst)
    step && last_q |=> pos == '0 && found == '0 && !stopped)
    else $error("parse state not cleared after packet end");

  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    !(step && last_q) |=> (found & $past(found)) == $past(found))
    else $error("found flag dropped inside a packet");

endmodule

`default_nettype wire

### hw/rtl/bdp_result_stage.sv
// ----------------------------------------------------------------------------
// bdp_result_stage
// Packet store, UUID lookup at the queried index and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdp_result_stage #(
  parameter int PACKET_BYTES = 255
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [7:0]                        query_index,
  input  logic                              wr_en,
  input  logic [$clog2(PACKET_BYTES)-1:0]   wr_addr,
  input  logic [7:0]                        wr_data,
  input  logic                              sum_valid,
  input  bdp_pkg::summary_t                 summary,
  output logic                              s3_ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        name_type,
  output logic [7:0]                        name_offset,
  output logic [7:0]                        name_length,
  output logic                              has_uuid,
  output logic [6:0]                        uuid_count,
  output logic [15:0]                       uuid_at_index
);

  localparam int IDXW = $clog2(PACKET_BYTES);

  logic [7:0]      mem [PACKET_BYTES];
  logic [7:0]      lo_q, hi_q;
  logic            in_range_q;
  logic            adv;
  logic            in_p, in_f;
  logic [7:0]      rel;
  logic [7:0]      base;
  logic [7:0]      idx;
  logic [8:0]      lo_addr, hi_addr;
  logic [IDXW-1:0] rd_lo, rd_hi;

  assign s3_ready = !out_valid || !out_stall;
  assign adv      = sum_valid && s3_ready;

  always_comb begin
    in_p    = query_index < {1'b0, summary.partial_count};
    rel     = query_index - {1'b0, summary.partial_count};
    in_f    = !in_p && (rel < {1'b0, summary.full_count});
    base    = in_p ? summary.partial_offset : summary.full_offset;
    idx     = in_p ? query_index : rel;
    lo_addr = {1'b0, base} + {idx, 1'b0};
    hi_addr = lo_addr + 9'd1;
    rd_lo   = IDXW'(lo_addr);
    rd_hi   = IDXW'(hi_addr);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_q <= mem[rd_lo];
      hi_q <= mem[rd_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      name_type   <= summary.name_type;
      name_offset <= summary.name_offset;
      name_length <= summary.name_length;
      has_uuid    <= summary.has_uuid;
      uuid_count  <= summary.uuid_count;
      in_range_q  <= in_p || in_f;
    end
  end

  assign uuid_at_index = in_range_q ? {hi_q, lo_q} : 16'd0;

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    sum_valid && s3_ready |=> out_valid)
    else $error("summary transfer did not load the output register");

endmodule

`default_nettype wire

### hw/rtl/ble_advertising_data_parser_top.sv
// ----------------------------------------------------------------------------
// ble_advertising_data_parser_top
// Streaming parser of BLE advertising data structures.
//
// Usage:
//   Input channel (in_valid/in_stall, data_byte, last_byte) takes one packet
//   byte per transfer, last_byte set on the final byte. Bytes beyond
//   PACKET_BYTES are dropped, but a dropped final byte still ends the packet.
//   Output channel (out_valid/out_stall) carries one result per packet: name
//   type/offset/length, has_uuid, uuid_count and uuid_at_index.
//   Configuration goes through the APB port (byte addresses 0..20). Write it
//   only while no packet is in flight; the block itself does not enforce this.
//   Throughput: one byte per cycle while in_stall is low; a new packet may
//   follow its predecessor with no gap. Each byte goes through the input
//   register, the field walk and the summary register; the UUID lookup reads
//   the packet store once. After the final byte's transfer the result goes
//   through the input, summary and output registers in turn.
//   Stall: while out_stall holds a result and a second summary waits,
//   in_stall rises and the walk holds; otherwise bytes keep flowing.
//   Reset: registers return to their defaults, the pipeline empties and the
//   parser waits for the first byte of a new packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ble_advertising_data_parser_top #(
  parameter int PACKET_BYTES = 255
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bdp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bdp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bdp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      name_type,
  output logic [7:0]                      name_offset,
  output logic [7:0]                      name_length,
  output logic                            has_uuid,
  output logic [6:0]                      uuid_count,
  output logic [15:0]                     uuid_at_index
);

  localparam int IDXW = $clog2(PACKET_BYTES);

  bdp_pkg::cfg_t     cfg;
  bdp_pkg::summary_t summary;
  logic              sum_valid;
  logic              s3_ready;
  logic              wr_en;
  logic [IDXW-1:0]   wr_addr;
  logic [7:0]        wr_data;

  bdp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdp_field_walker #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .s3_ready  (s3_ready),
    .sum_valid (sum_valid),
    .summary   (summary),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  bdp_result_stage #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_result (
    .clk           (clk),
    .rst           (rst),
    .query_index   (cfg.query_index),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .sum_valid     (sum_valid),
    .summary       (summary),
    .s3_ready      (s3_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .name_type     (name_type),
    .name_offset   (name_offset),
    .name_length   (name_length),
    .has_uuid      (has_uuid),
    .uuid_count    (uuid_count),
    .uuid_at_index (uuid_at_index)
  );

endmodule

`default_nettype wire

### verif/adv_summary_checker.sv
// ----------------------------------------------------------------------------
// adv_summary_checker
// Watches the register port and both channels of the advertising data parser,
// rebuilds each packet, predicts its summary at the final byte and compares
// every summary transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adv_summary_checker #(
  parameter int PACKET_BYTES = 255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bdp_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                           pready,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     name_type,
  input  logic [7:0]                     name_offset,
  input  logic [7:0]                     name_length,
  input  logic                           has_uuid,
  input  logic [6:0]                     uuid_count,
  input  logic [15:0]                    uuid_at_index,
  output int                             failures,
  output int                             pending
);

  typedef struct packed {
    logic [7:0]  name_type;
    logic [7:0]  name_offset;
    logic [7:0]  name_length;
    logic        has_uuid;
    logic [6:0]  uuid_count;
    logic [15:0] uuid_at_index;
  } adv_summary_t;

  bdp_pkg::cfg_t cfg;
  logic [7:0]    pkt_bytes [PACKET_BYTES];
  int unsigned   pkt_len;
  adv_summary_t  summary_q [$];
  adv_summary_t  head;

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic bit find_field(input int unsigned size, input logic [7:0] ad_type,
                                    output int unsigned off, output int unsigned plen);
    int unsigned pos;
    int unsigned flen;
    pos  = 0;
    off  = 0;
    plen = 0;
    while (pos + 1 < size) begin
      flen = pkt_bytes[pos];
      if (flen == 0 || pos + 1 + flen > size) return 1'b0;
      if (pkt_bytes[pos + 1] == ad_type) begin
        off  = pos + 2;
        plen = flen - 1;
        return 1'b1;
      end
      pos += flen + 1;
    end
    return 1'b0;
  endfunction

  function automatic adv_summary_t predict_summary(input int unsigned size);
    adv_summary_t s;
    int unsigned  off;
    int unsigned  plen;
    int unsigned  tally;
    int unsigned  u;
    logic [7:0]   lists [2];
    s        = '0;
    tally    = 0;
    lists[0] = cfg.partial_list_type;
    lists[1] = cfg.full_list_type;
    if (find_field(size, cfg.complete_name_type, off, plen)) begin
      s.name_type   = cfg.complete_name_type;
      s.name_offset = off[7:0];
      s.name_length = plen[7:0];
    end else if (find_field(size, cfg.short_name_type, off, plen)) begin
      s.name_type   = cfg.short_name_type;
      s.name_offset = off[7:0];
      s.name_length = plen[7:0];
    end
    for (int l = 0; l < 2; l++) begin
      if (find_field(size, lists[l], off, plen)) begin
        if (cfg.query_uuid == 16'd0 && plen >= 2) s.has_uuid = 1'b1;
        for (int unsigned j = 0; j + 1 < plen; j += 2) begin
          u = {pkt_bytes[off + j + 1], pkt_bytes[off + j]};
          if (u == cfg.query_uuid) s.has_uuid = 1'b1;
          if (tally == cfg.query_index) s.uuid_at_index = u[15:0];
          tally++;
        end
      end
    end
    s.uuid_count = tally[6:0];
    return s;
  endfunction

  function automatic void check_field(input string label, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.query_uuid         = 16'd0;
      cfg.query_index        = 8'd0;
      cfg.complete_name_type = bdp_pkg::RST_COMPLETE_NAME;
      cfg.short_name_type    = bdp_pkg::RST_SHORT_NAME;
      cfg.partial_list_type  = bdp_pkg::RST_PARTIAL_LIST;
      cfg.full_list_type     = bdp_pkg::RST_FULL_LIST;
      pkt_len                = 0;
      summary_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[bdp_pkg::APB_ADDR_W-1:2])
          bdp_pkg::REG_QUERY_UUID:    cfg.query_uuid         = pwdata[15:0];
          bdp_pkg::REG_QUERY_INDEX:   cfg.query_index        = pwdata[7:0];
          bdp_pkg::REG_COMPLETE_NAME: cfg.complete_name_type = pwdata[7:0];
          bdp_pkg::REG_SHORT_NAME:    cfg.short_name_type    = pwdata[7:0];
          bdp_pkg::REG_PARTIAL_LIST:  cfg.partial_list_type  = pwdata[7:0];
          bdp_pkg::REG_FULL_LIST:     cfg.full_list_type     = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (summary_q.size() == 0) begin
          $error("summary transfer with no packet summary outstanding");
          failures++;
        end else begin
          head = summary_q.pop_front();
          check_field("name_type", 16'(head.name_type), 16'(name_type));
          check_field("name_offset", 16'(head.name_offset), 16'(name_offset));
          check_field("name_length", 16'(head.name_length), 16'(name_length));
          check_field("has_uuid", 16'(head.has_uuid), 16'(has_uuid));
          check_field("uuid_count", 16'(head.uuid_count), 16'(uuid_count));
          check_field("uuid_at_index", head.uuid_at_index, uuid_at_index);
        end
      end
      if (in_valid && !in_stall) begin
        if (pkt_len < PACKET_BYTES) begin
          pkt_bytes[pkt_len] = data_byte;
          pkt_len++;
        end
        if (last_byte) begin
          summary_q.push_back(predict_summary(pkt_len));
          pkt_len = 0;
        end
      end
    end
    pending = summary_q.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives advertising packets byte by byte into the parser through several
// register settings: a short directed set, then mostly well-formed random
// packets with broken and noise packets mixed in, plus full-size and
// overlong packets. Both channels idle at random; the checker judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int PACKET_BYTES = 255;
  localparam int PHASE_ITEMS  = 180;
  localparam int NUM_PHASES   = 6;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int DIR_LEN = 24;
  localparam logic [7:0] DIR_BYTES [DIR_LEN] = '{
    8'hFF,
    8'h00, 8'h09, 8'h41,
    8'h03, 8'h08, 8'h41, 8'h42, 8'h01, 8'h09,
    8'h06, 8'h02, 8'h0D, 8'h18, 8'h0F, 8'h18, 8'hAA,
    8'h03, 8'h03, 8'h0A, 8'h18, 8'h00,
    8'h02, 8'h09
  };
  localparam logic [DIR_LEN-1:0] DIR_ENDS = 24'hA0_0009;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [bdp_pkg::APB_ADDR_W-1:0] paddr;
  logic [bdp_pkg::APB_DATA_W-1:0] pwdata;
  logic [bdp_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     data_byte;
  logic                           last_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic [7:0]                     name_type;
  logic [7:0]                     name_offset;
  logic [7:0]                     name_length;
  logic                           has_uuid;
  logic [6:0]                     uuid_count;
  logic [15:0]                    uuid_at_index;
  int                             failures;
  int                             pending;

  logic [15:0] q_uuid;
  logic [7:0]  q_index;
  logic [7:0]  t_cname;
  logic [7:0]  t_sname;
  logic [7:0]  t_plist;
  logic [7:0]  t_flist;
  bit          calm;
  int unsigned sent_items;
  logic [7:0]  adv_bytes [$];

  always #4 clk = ~clk;

  ble_advertising_data_parser_top #(
    .PACKET_BYTES (PACKET_BYTES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .name_type     (name_type),
    .name_offset   (name_offset),
    .name_length   (name_length),
    .has_uuid      (has_uuid),
    .uuid_count    (uuid_count),
    .uuid_at_index (uuid_at_index)
  );

  adv_summary_checker #(
    .PACKET_BYTES (PACKET_BYTES)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .name_type     (name_type),
    .name_offset   (name_offset),
    .name_length   (name_length),
    .has_uuid      (has_uuid),
    .uuid_count    (uuid_count),
    .uuid_at_index (uuid_at_index),
    .failures      (failures),
    .pending       (pending)
  );

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] qu, input logic [7:0] qi, input logic [7:0] cn,
                              input logic [7:0] sn, input logic [7:0] pl, input logic [7:0] fl);
    q_uuid  = qu;
    q_index = qi;
    t_cname = cn;
    t_sname = sn;
    t_plist = pl;
    t_flist = fl;
    apb_write(bdp_pkg::REG_QUERY_UUID, {16'($urandom), qu});
    apb_write(bdp_pkg::REG_QUERY_INDEX, {24'($urandom), qi});
    apb_write(bdp_pkg::REG_COMPLETE_NAME, {24'($urandom), cn});
    apb_write(bdp_pkg::REG_SHORT_NAME, {24'($urandom), sn});
    apb_write(bdp_pkg::REG_PARTIAL_LIST, {24'($urandom), pl});
    apb_write(bdp_pkg::REG_FULL_LIST, {24'($urandom), fl});
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_packet();
    foreach (adv_bytes[i]) send_byte(adv_bytes[i], i == adv_bytes.size() - 1);
  endtask

  // hold the sender until every summary has arrived and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_field(input logic [7:0] ad_type, input int unsigned plen, input bit is_list);
    int unsigned k;
    adv_bytes.push_back(8'(plen + 1));
    adv_bytes.push_back(ad_type);
    k = 0;
    while (k < plen) begin
      if (is_list && k % 2 == 0 && k + 1 < plen && $urandom_range(0, 3) == 0) begin
        adv_bytes.push_back(q_uuid[7:0]);
        adv_bytes.push_back(q_uuid[15:8]);
        k += 2;
      end else begin
        adv_bytes.push_back(8'($urandom));
        k++;
      end
    end
  endtask

  task automatic gen_packet();
    int unsigned mode;
    int unsigned pick;
    int unsigned plen;
    int unsigned cut;
    logic [7:0]  ad_type;
    bit          is_list;
    adv_bytes.delete();
    mode = $urandom_range(0, 99);
    if (mode < 12) begin
      repeat ($urandom_range(1, 40)) adv_bytes.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      pick    = $urandom_range(0, 9);
      is_list = 1'b0;
      case (pick)
        0, 1: begin
          ad_type = t_cname;
          plen    = $urandom_range(0, 8);
        end
        2: begin
          ad_type = t_sname;
          plen    = $urandom_range(0, 8);
        end
        3, 4: begin
          ad_type = t_plist;
          plen    = $urandom_range(0, 9);
          is_list = 1'b1;
        end
        5, 6: begin
          ad_type = t_flist;
          plen    = $urandom_range(0, 9);
          is_list = 1'b1;
        end
        default: begin
          ad_type = 8'($urandom);
          plen    = $urandom_range(0, 5);
        end
      endcase
      add_field(ad_type, plen, is_list);
    end
    if (mode < 25) begin
      if (adv_bytes.size() > 1) begin
        cut = $urandom_range(1, adv_bytes.size() - 1);
        repeat (cut) adv_bytes.delete(adv_bytes.size() - 1);
      end
    end else if (mode < 35) begin
      adv_bytes.push_back(8'h00);
      add_field(t_cname, 2, 1'b0);
    end else if (mode < 43) begin
      adv_bytes.push_back(8'($urandom_range(5, 40)));
      adv_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int unsigned phase_start;
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    data_byte  <= 8'h00;
    last_byte  <= 1'b0;
    calm       = 1'b0;
    sent_items = 0;
    q_uuid     = 16'd0;
    q_index    = 8'd0;
    t_cname    = bdp_pkg::RST_COMPLETE_NAME;
    t_sname    = bdp_pkg::RST_SHORT_NAME;
    t_plist    = bdp_pkg::RST_PARTIAL_LIST;
    t_flist    = bdp_pkg::RST_FULL_LIST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_LEN; i++) send_byte(DIR_BYTES[i], DIR_ENDS[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == NUM_PHASES - 1);
      case (p)
        0: begin
          program_regs(16'd0, 8'd0, bdp_pkg::RST_COMPLETE_NAME, bdp_pkg::RST_SHORT_NAME,
                       bdp_pkg::RST_PARTIAL_LIST, bdp_pkg::RST_FULL_LIST);
          apb_write(REG_SPARE_LO, $urandom);
          apb_write(REG_SPARE_HI, $urandom);
        end
        1: program_regs(16'h180F, 8'd1, bdp_pkg::RST_COMPLETE_NAME, bdp_pkg::RST_SHORT_NAME,
                        bdp_pkg::RST_PARTIAL_LIST, bdp_pkg::RST_FULL_LIST);
        2: program_regs(16'hFFFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00);
        3: program_regs(16'($urandom), 8'd200, 8'h21, 8'h21, 8'h07, 8'h07);
        4: program_regs(16'($urandom), 8'($urandom_range(0, 12)), 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom));
        default: program_regs(16'h0001, 8'd0, bdp_pkg::RST_COMPLETE_NAME,
                              bdp_pkg::RST_SHORT_NAME, bdp_pkg::RST_FULL_LIST,
                              bdp_pkg::RST_PARTIAL_LIST);
      endcase
      if (p == 3) begin
        adv_bytes.delete();
        add_field(t_plist, PACKET_BYTES - 2, 1'b1);
        send_packet();
        adv_bytes.delete();
        add_field(t_cname, 3, 1'b0);
        add_field(t_flist, 6, 1'b1);
        while (adv_bytes.size() < PACKET_BYTES + $urandom_range(1, 6))
          adv_bytes.push_back(8'($urandom));
        send_packet();
      end
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) begin
        if (p != NUM_PHASES - 1) calm = ($urandom_range(0, 7) == 0);
        gen_packet();
        send_packet();
        if ($urandom_range(0, 19) == 0) drain();
      end
      drain();
    end

    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
